FILE: sv/sha256_stream_hash_defines.svh
// Assertion macros used by the hash engine.
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sha_pkg.sv
// Package with the types, constants and functions of the SHA-256 stream hash.
package sha_pkg;

    // Command passed from the front end to the compression engine.
    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_FINAL = 2'd1
    } sha_cmd_t;

    // One queued item between front end and engine.
    typedef struct packed {
        sha_cmd_t    cmd;
        logic [7:0]  data;
        logic        present;
    } sha_item_t;

    // Engine states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    localparam logic [60:0] COUNT_MAX = {61{1'b1}};
    localparam logic [7:0]  PAD_BYTE  = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: sv/sha_front.sv
// Front end: accepts items, classifies them and queues them for the engine.
module sha_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               byte_present,
    input  logic               last_byte,
    input  logic               push,
    output logic               full,
    output sha_pkg::sha_item_t q_item,
    output logic               q_valid,
    input  logic               q_take
);
    import sha_pkg::*;

    localparam int DEPTH = 4;

    sha_item_t  fifo_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       wr_en, rd_en;
    sha_item_t  item_in;

    // An item with neither byte nor end mark does nothing and is dropped.
    always_comb
    begin
        item_in.cmd     = last_byte ? CMD_FINAL : CMD_DATA;
        item_in.data    = data_byte;
        item_in.present = byte_present;
        full    = (count_reg == 3'(DEPTH));
        wr_en   = push && !full && (byte_present || last_byte);
        q_valid = (count_reg != 3'd0);
        rd_en   = q_take && q_valid;
        q_item  = fifo_reg[rd_ptr_reg];
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(wr_en) - 3'(rd_en);
        end
    end

endmodule

FILE: sv/sha_engine.sv
// Back end: gathers bytes into blocks, runs the rounds, pads and emits the digest.
module sha_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::sha_item_t q_item,
    input  logic               q_valid,
    output logic               q_take,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word,
    output logic               empty,
    input  logic               pop
);
    import sha_pkg::*;
    `include "sha256_stream_hash_defines.svh"

    sha_state_t  state_reg, state_next;
    // Block buffer as sixteen big-endian words, written one byte lane at a time.
    logic [31:0] buf_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [60:0] cnt_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  out_reg;
    // Padding phase: 0 writes 0x80, 1 zeroes to the end, 2 writes any leading zeros and the length, 3 is done.
    logic [1:0]  pad_reg;
    logic [5:0]  pad_idx_reg;
    logic        final_reg;
    logic        two_blk_reg;

    logic        take_data;
    logic [31:0] w_cur, s0, s1, t1, t2, w_new;
    logic [31:0] ea, eb, ec, ee, ef, eg;
    logic [63:0] bit_len;
    logic        do_pop;
    logic [4:0]  fill_lane, pad_lane;

    // Round datapath: one SHA-256 round per cycle.
    always_comb
    begin
        ea = v_reg[0];
        eb = v_reg[1];
        ec = v_reg[2];
        ee = v_reg[4];
        ef = v_reg[5];
        eg = v_reg[6];
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = (rnd_reg < 6'd16) ? w_reg[0] : w_new;
        t1 = v_reg[7] + (rotr(ee, 6) ^ rotr(ee, 11) ^ rotr(ee, 25))
           + ((ee & ef) ^ (~ee & eg)) + ROUND_K[rnd_reg] + w_cur;
        t2 = (rotr(ea, 2) ^ rotr(ea, 13) ^ rotr(ea, 22)) + ((ea & eb) ^ (ea & ec) ^ (eb & ec));
        bit_len = {cnt_reg, 3'b000};
        // Byte 0 of a word sits in its top lane.
        fill_lane = 5'd24 - {fill_reg[1:0], 3'b000};
        pad_lane  = 5'd24 - {pad_idx_reg[1:0], 3'b000};
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.present && fill_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (q_item.cmd == CMD_FINAL)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (pad_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pad_reg == 2'd2 && pad_idx_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
                else if (pad_reg == 2'd1 && pad_idx_reg == 6'd63 && two_blk_reg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (do_pop && out_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        take_data   = (state_reg == ST_IDLE) && q_valid;
        q_take      = take_data;
        empty       = (state_reg != ST_EMIT);
        do_pop      = pop && !empty;
        digest_word = h_reg[out_reg];
        word_index  = out_reg;
        last_word   = (out_reg == 3'd7);
    end

    // Block buffer memory, one byte written per cycle while bytes are taken or padding runs.
    always_ff @(posedge clk)
    begin
        if (take_data && q_item.present)
        begin
            buf_reg[fill_reg[5:2]][fill_lane +: 8] <= q_item.data;
        end
        else if (state_reg == ST_PAD)
        begin
            if (pad_reg == 2'd0)
            begin
                buf_reg[fill_reg[5:2]][fill_lane +: 8] <= PAD_BYTE;
            end
            else if (pad_reg == 2'd1 && pad_idx_reg != fill_reg)
            begin
                // The pad byte itself stays when it landed in the last slot.
                buf_reg[pad_idx_reg[5:2]][pad_lane +: 8] <= 8'h00;
            end
            else if (pad_reg == 2'd2)
            begin
                buf_reg[pad_idx_reg[5:2]][pad_lane +: 8] <= (pad_idx_reg < 6'd56) ? 8'h00
                    : bit_len[{~pad_idx_reg[2:0], 3'b000} +: 8];
            end
        end
    end

    // Schedule window and working variables.
    always_ff @(posedge clk)
    begin
        if (state_next == ST_ROUND && state_reg != ST_ROUND)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (state_reg == ST_IDLE && i == 15)
                begin
                    w_reg[i] <= {buf_reg[15][31:8], q_item.data};
                end
                else if (state_reg == ST_PAD && pad_reg == 2'd2 && i == 15)
                begin
                    w_reg[i] <= bit_len[31:0];
                end
                else if (state_reg == ST_PAD && pad_reg == 2'd2 && i == 14)
                begin
                    w_reg[i] <= bit_len[63:32];
                end
                else if (state_reg == ST_PAD && i == 15)
                begin
                    // The last byte is being zeroed this cycle unless it holds the pad byte.
                    w_reg[i] <= {buf_reg[15][31:8],
                                 (fill_reg == 6'd63) ? buf_reg[15][7:0] : 8'h00};
                end
                else
                begin
                    w_reg[i] <= buf_reg[i];
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Control registers and chaining hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            out_reg     <= '0;
            pad_reg     <= '0;
            pad_idx_reg <= '0;
            final_reg   <= 1'b0;
            two_blk_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take_data)
            begin
                if (q_item.present)
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (cnt_reg != COUNT_MAX)
                    begin
                        cnt_reg <= cnt_reg + 61'd1;
                    end
                end
                final_reg <= (q_item.cmd == CMD_FINAL);
                pad_reg   <= '0;
            end
            if (state_reg == ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
                if (final_reg && two_blk_reg)
                begin
                    // Second padding block: zeros then length.
                    two_blk_reg <= 1'b0;
                    pad_reg     <= 2'd2;
                    pad_idx_reg <= '0;
                end
            end
            if (state_reg == ST_PAD)
            begin
                unique case (pad_reg)
                    2'd0:
                    begin
                        two_blk_reg <= (fill_reg >= 6'd56);
                        pad_idx_reg <= (fill_reg == 6'd63) ? 6'd63 : fill_reg + 6'd1;
                        pad_reg     <= 2'd1;
                    end
                    2'd1:
                    begin
                        if (pad_idx_reg == 6'd63)
                        begin
                            // With two blocks the update after this one starts the second.
                            if (!two_blk_reg)
                            begin
                                pad_reg     <= 2'd2;
                                pad_idx_reg <= 6'd56;
                            end
                        end
                        else
                        begin
                            pad_idx_reg <= pad_idx_reg + 6'd1;
                        end
                    end
                    2'd2:
                    begin
                        if (pad_idx_reg == 6'd63)
                        begin
                            pad_reg <= 2'd3;
                        end
                        else
                        begin
                            pad_idx_reg <= pad_idx_reg + 6'd1;
                        end
                    end
                    default:
                    begin
                        pad_reg <= pad_reg;
                    end
                endcase
            end
            if (state_reg == ST_UPDATE && final_reg && pad_reg == 2'd3)
            begin
                out_reg <= '0;
            end
            if (do_pop)
            begin
                out_reg <= out_reg + 3'd1;
                if (out_reg == 3'd7)
                begin
                    // Back to the reset state for the next message.
                    cnt_reg     <= '0;
                    fill_reg    <= '0;
                    final_reg   <= 1'b0;
                    two_blk_reg <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= INIT_HASH[i];
                    end
                end
            end
        end
    end

    `SHA_ASSERT_IMPL(a_take_idle, clk, rst_n, q_take, state_reg == ST_IDLE, "take outside idle")
    `SHA_ASSERT_NEXT(a_round_run, clk, rst_n, state_reg == ST_ROUND && rnd_reg != 6'd63,
        state_reg == ST_ROUND, "round loop broke early")
    `SHA_ASSERT_IMPL(a_emit_index, clk, rst_n, !empty, last_word == (word_index == 3'd7),
        "last word mismatch")

endmodule

FILE: sv/sha256_stream_hash.sv
// SHA-256 of a byte stream: at most one byte per item in, eight 32-bit digest words out.
// The front queue takes an item per cycle while it has room (four entries); the
// engine writes one byte per cycle into the 64-byte buffer while it is idle and,
// on each full block, runs the compression at one round per cycle, taking no new
// bytes until it is done. At the end mark the padding is written one byte per
// cycle into the buffer (with a second compression when fewer than nine bytes
// are free) before the eight words appear in order, the last with last_word set.
module sha256_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    input  logic        push,
    output logic        full,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        empty,
    input  logic        pop
);
    import sha_pkg::*;

    sha_item_t q_item;
    logic      q_valid;
    logic      q_take;

    sha_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .push         (push),
        .full         (full),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_take       (q_take)
    );

    sha_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_take      (q_take),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
